// File: hw/rtl/pmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmq_pkg: shared types and constants for the predictive minifloat quantizer
// Fixed-point formats, controller states and controller/datapath buses.
// ----------------------------------------------------------------------------
package pmq_pkg;

	// fixed-point formats
	localparam int SAMPLE_FRAC_BITS   = 16;
	localparam int RESIDUAL_FRAC_BITS = 32;
	localparam int SAMPLE_W           = 32;
	localparam int MAG_W              = 40;
	localparam int PRED_W             = 36;
	localparam int DIFF_W             = 37;
	localparam int RECIP_W            = 48;
	localparam int AMP_W              = 31;
	localparam int CHUNK_W            = 16;
	localparam int ACC_W              = DIFF_W + RECIP_W;
	localparam int CODE_W             = 24;
	localparam int SIG_W              = 17;
	localparam int PROD_W             = SIG_W + AMP_W + 1;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 48;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXP_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIG_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_OFS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP    = 3'd4;

	// predictor types
	localparam logic [1:0] PT_PREV   = 2'd0;
	localparam logic [1:0] PT_LINEAR = 2'd1;
	localparam logic [1:0] PT_QUAD   = 2'd2;
	localparam logic [1:0] PT_TWO    = 2'd3;

	// last partial product index of one residual multiply
	localparam logic [1:0] LAST_CHUNK = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_RND,
		ST_EXP,
		ST_SIG,
		ST_DEC,
		ST_REC
	} state_t;

	typedef struct packed {
		logic       load;
		logic       diff;
		logic       mul;
		logic       rnd;
		logic       expo;
		logic       sig;
		logic       dec;
		logic       rec;
		logic [1:0] pidx;
		logic [1:0] chunk;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage : pmq_pkg
`default_nettype wire

// File: hw/rtl/pmq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmq_dp: quantizer datapath
// History, shared residual multiplier, predictor choice, minifloat coding,
// decode and reconstruction, output register.
// ----------------------------------------------------------------------------
module pmq_dp import pmq_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_wdata,
	input  wire cmd_t                         cmd,
	output status_t                           status,
	input  wire logic signed [SAMPLE_W-1:0]   in_sample,
	input  wire logic                         in_first_channel,
	input  wire logic                         in_first_trace,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [CODE_W-1:0]                 out_code,
	output logic [1:0]                        out_type,
	output logic signed [SAMPLE_W-1:0]        out_recon,
	output logic [MAG_W-1:0]                  out_max
);

	localparam int SHIFT = SAMPLE_FRAC_BITS + 32 - RESIDUAL_FRAC_BITS;
	localparam logic [MAG_W-1:0] RES_MAX = '1;

	// configuration registers
	logic [2:0]          eb_q;
	logic [4:0]          sb_q;
	logic [6:0]          off_q;
	logic [AMP_W-1:0]    amp_q;
	logic [RECIP_W-1:0]  recip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eb_q    <= 3'd4;
			sb_q    <= 5'd10;
			off_q   <= 7'd14;
			amp_q   <= 31'd65536;
			recip_q <= 48'h0001_0000_0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXP_BITS: eb_q    <= cfg_wdata[2:0];
				REG_SIG_BITS: sb_q    <= cfg_wdata[4:0];
				REG_EXP_OFS:  off_q   <= cfg_wdata[6:0];
				REG_AMP:      amp_q   <= cfg_wdata[AMP_W-1:0];
				REG_RECIP:    recip_q <= cfg_wdata[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	// field widths clamped to the legal range
	logic [2:0]        ebc;
	logic [4:0]        sbc;
	logic signed [9:0] offx;
	logic signed [9:0] rfbx;

	always_comb begin
		ebc  = (eb_q == 3'd0) ? 3'd1 : ((eb_q > 3'd6) ? 3'd6 : eb_q);
		sbc  = (sb_q < 5'd2) ? 5'd2 : ((sb_q > 5'd16) ? 5'd16 : sb_q);
		offx = $signed({{3{off_q[6]}}, off_q});
		rfbx = $signed(10'(RESIDUAL_FRAC_BITS));
	end

	// history and running maximum
	logic signed [SAMPLE_W-1:0] h1_q, h2_q, h3_q, sample_q;
	logic [MAG_W-1:0]           max_q;

	// predictions from history
	logic signed [PRED_W-1:0] h1x, h2x, h3x, dlt;
	logic signed [PRED_W-1:0] pred [4];

	always_comb begin
		h1x = PRED_W'(h1_q);
		h2x = PRED_W'(h2_q);
		h3x = PRED_W'(h3_q);
		dlt = h1x - h2x;
		pred[0] = h1x;
		pred[1] = (h1x <<< 1) - h2x;
		pred[2] = h3x + (dlt <<< 1) + dlt;
		pred[3] = h2x;
	end

	// residual of the predictor in work
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        abs_s1;
	logic                     neg_s1;

	assign diff = DIFF_W'(sample_q) - DIFF_W'(pred[cmd.pidx]);

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			neg_s1 <= diff[DIFF_W-1];
			abs_s1 <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		end
	end

	// shared multiplier, one 16-bit slice of the reciprocal per cycle
	logic [ACC_W-1:0]             acc_q;
	logic [DIFF_W+CHUNK_W-1:0]    pp;
	logic [ACC_W-1:0]             ppx;

	assign pp  = abs_s1 * recip_q[CHUNK_W*cmd.chunk +: CHUNK_W];
	assign ppx = ACC_W'(pp) << (CHUNK_W * cmd.chunk);

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			acc_q <= '0;
		end else if (cmd.mul) begin
			acc_q <= acc_q + ppx;
		end
	end

	// rounding and saturation of the normalized magnitude
	logic [ACC_W:0]   rsum, rsh;
	logic [MAG_W-1:0] mag;

	always_comb begin
		rsum = {1'b0, acc_q} + ((ACC_W+1)'(1) << (SHIFT - 1));
		rsh  = rsum >> SHIFT;
		mag  = (rsh[ACC_W:MAG_W] != '0) ? RES_MAX : rsh[MAG_W-1:0];
	end

	// running strict minimum, ties fall back to the previous-sample predictor
	logic [MAG_W-1:0] best_q, mag0_q;
	logic [1:0]       idx_q;
	logic             tie_q, best_neg_q, neg0_q;

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			if (cmd.pidx == PT_PREV) begin
				best_q     <= mag;
				best_neg_q <= neg_s1;
				idx_q      <= PT_PREV;
				tie_q      <= 1'b0;
				mag0_q     <= mag;
				neg0_q     <= neg_s1;
			end else if (mag < best_q) begin
				best_q     <= mag;
				best_neg_q <= neg_s1;
				idx_q      <= cmd.pidx;
				tie_q      <= 1'b0;
			end else if (mag == best_q) begin
				tie_q <= 1'b1;
			end
		end
	end

	// biased exponent of the chosen residual
	logic [MAG_W-1:0]  msel;
	logic [5:0]        bl;
	logic signed [9:0] ev;
	logic [5:0]        bmax;
	logic [5:0]        bb_v;

	always_comb begin
		msel = tie_q ? mag0_q : best_q;
		bl   = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (msel[i]) bl = 6'(i + 1);
		end
		ev   = $signed({4'b0, bl}) - rfbx + offx;
		bmax = 6'((7'd1 << ebc) - 7'd1);
		if (msel == '0 || ev < 10'sd0) bb_v = '0;
		else if (ev > $signed({4'b0, bmax})) bb_v = bmax;
		else bb_v = ev[5:0];
	end

	logic [MAG_W-1:0] m_q;
	logic             ng_q;
	logic [1:0]       type_q;
	logic [5:0]       bb_q;

	always_ff @(posedge clk) begin
		if (cmd.expo) begin
			m_q    <= msel;
			ng_q   <= tie_q ? neg0_q : best_neg_q;
			type_q <= tie_q ? PT_PREV : idx_q;
			bb_q   <= bb_v;
		end
	end

	// significand, rounded and saturated
	logic signed [9:0]       kk;
	logic [9:0]              nk;
	logic [SIG_W-1:0]        lim, qc;
	logic [MAG_W+15:0]       qw;
	logic [MAG_W:0]          qr;
	logic signed [SIG_W-1:0] sig_v;
	logic [CODE_W-1:0]       code_v;

	always_comb begin
		kk  = $signed({5'b0, sbc}) - 10'sd1 - $signed({4'b0, bb_q}) + offx - rfbx;
		nk  = 10'(-kk);
		lim = (SIG_W'(1) << (sbc - 5'd1)) - (ng_q ? SIG_W'(0) : SIG_W'(1));
		qw  = '0;
		qr  = '0;
		if (!kk[9]) begin
			qw = (MAG_W+16)'(m_q) << kk[3:0];
			if (m_q != '0 && kk > 10'sd15) qc = lim;
			else qc = (qw > (MAG_W+16)'(lim)) ? lim : SIG_W'(qw);
		end else if (nk > 10'd41) begin
			qc = '0;
		end else begin
			qr = ({1'b0, m_q} + ((MAG_W+1)'(1) << (nk[5:0] - 6'd1))) >> nk[5:0];
			qc = (qr > (MAG_W+1)'(lim)) ? lim : SIG_W'(qr);
		end
		sig_v  = ng_q ? $signed(SIG_W'(-qc)) : $signed(qc);
		code_v = (CODE_W'(type_q) << (ebc + 3'(0) + sbc))
		       | (CODE_W'(bb_q) << sbc)
		       | (CODE_W'(sig_v[15:0]) & ((CODE_W'(1) << sbc) - CODE_W'(1)));
	end

	logic signed [SIG_W-1:0] sig_q;
	logic [CODE_W-1:0]       code_q;

	always_ff @(posedge clk) begin
		if (cmd.sig) begin
			sig_q  <= sig_v;
			code_q <= code_v;
		end
	end

	// decode: significand times amplitude
	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			prod_s1 <= PROD_W'(sig_q) * $signed({1'b0, amp_q});
		end
	end

	// scale decoded residual and add to the chosen prediction
	logic                     pneg;
	logic [47:0]              pm, pmsh;
	logic [48:0]              pmr;
	logic [MAG_W:0]           pm2;
	logic signed [9:0]        dd;
	logic [9:0]               nd;
	logic signed [MAG_W+1:0]  delta;
	logic signed [MAG_W+2:0]  rsum2;
	logic signed [SAMPLE_W-1:0] recon_v;
	logic [MAG_W-1:0]         max_v;

	always_comb begin
		pneg = prod_s1[PROD_W-1];
		pm   = pneg ? 48'(-prod_s1) : 48'(prod_s1);
		dd   = $signed({4'b0, bb_q}) - offx - $signed({5'b0, sbc}) + 10'sd1;
		nd   = 10'(-dd);
		pmsh = '0;
		pmr  = '0;
		if (!dd[9]) begin
			pmsh = pm << dd[5:0];
			if (pm != '0 && (dd > 10'sd39 || pm > (48'd1 << MAG_W) >> dd[5:0]))
				pm2 = (MAG_W+1)'(1) << MAG_W;
			else
				pm2 = (MAG_W+1)'(pmsh);
		end else if (nd > 10'd48) begin
			pm2 = '0;
		end else begin
			pmr = ({1'b0, pm} + (49'd1 << (nd[5:0] - 6'd1))) >> nd[5:0];
			// a contribution this large saturates the sum either way
			if (pmr > (49'd1 << MAG_W))
				pm2 = (MAG_W+1)'(1) << MAG_W;
			else
				pm2 = (MAG_W+1)'(pmr);
		end
		delta = pneg ? -$signed({1'b0, pm2}) : $signed({1'b0, pm2});
		rsum2 = (MAG_W+3)'(pred[type_q]) + (MAG_W+3)'(delta);
		if (rsum2 > (MAG_W+3)'(32'sh7FFF_FFFF)) recon_v = 32'sh7FFF_FFFF;
		else if (rsum2 < -(MAG_W+3)'(33'sh0_8000_0000)) recon_v = 32'sh8000_0000;
		else recon_v = SAMPLE_W'(rsum2);
		max_v = (m_q > max_q) ? m_q : max_q;
	end

	// sample capture, history and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q  <= '0;
			h2_q  <= '0;
			h3_q  <= '0;
			max_q <= '0;
		end else if (cmd.load) begin
			if (in_first_channel) begin
				h1_q <= '0;
				h2_q <= '0;
				h3_q <= '0;
			end
			if (in_first_trace) max_q <= '0;
		end else if (cmd.rec) begin
			h1_q  <= recon_v;
			h2_q  <= h1_q;
			h3_q  <= h2_q;
			max_q <= max_v;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) sample_q <= in_sample;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.rec) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec) begin
			out_code  <= code_q;
			out_type  <= type_q;
			out_recon <= recon_v;
			out_max   <= max_v;
		end
	end

	assign status.out_free = !out_valid || out_ready;

endmodule : pmq_dp
`default_nettype wire

// File: hw/rtl/pmq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmq_ctrl: quantizer controller
// Sequences the four residual multiplies, the choice, coding and decode.
// ----------------------------------------------------------------------------
module pmq_ctrl import pmq_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output cmd_t         cmd,
	input  wire status_t status
);

	state_t     state_q, state_d;
	logic [1:0] k_q, k_d;
	logic [1:0] j_q, j_d;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			j_q     <= j_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		j_d       = j_q;
		cmd       = '0;
		cmd.pidx  = k_q;
		cmd.chunk = j_q;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					k_d      = PT_PREV;
					state_d  = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				j_d      = '0;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				j_d     = j_q + 2'd1;
				if (j_q == LAST_CHUNK) state_d = ST_RND;
			end
			ST_RND: begin
				cmd.rnd = 1'b1;
				if (k_q == PT_TWO) begin
					state_d = ST_EXP;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = ST_DIFF;
				end
			end
			ST_EXP: begin
				cmd.expo = 1'b1;
				state_d  = ST_SIG;
			end
			ST_SIG: begin
				cmd.sig = 1'b1;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				cmd.dec = 1'b1;
				state_d = ST_REC;
			end
			ST_REC: begin
				if (status.out_free) begin
					cmd.rec = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// checks
	a_rec_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rec |-> status.out_free) else $error("result loaded into busy output");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.diff, cmd.mul, cmd.rnd, cmd.expo, cmd.sig, cmd.dec, cmd.rec}))
		else $error("more than one datapath command");
	a_mul_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && j_q == LAST_CHUNK) |=> state_q == ST_RND)
		else $error("multiply pass length wrong");
	a_last_pred: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND && k_q == PT_TWO) |=> state_q == ST_EXP)
		else $error("predictor sweep did not end");

endmodule : pmq_ctrl
`default_nettype wire

// File: hw/rtl/predictive_minifloat_quantizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// predictive_minifloat_quantizer_top: lossy predictive minifloat coder
// One sample is in work at a time; the 37x16 residual multiplier is
// shared by four predictors at three partial products each.
// The next sample is taken while a result waits in the output register.
// Reset clears history, running maximum and control; registers get defaults.
// ----------------------------------------------------------------------------
module predictive_minifloat_quantizer_top import pmq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [31:0]           s_axis_tdata,  // sample
	input  wire logic [1:0]            s_axis_tuser,  // first_in_channel, first_in_trace
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [95:0]                m_axis_tdata,  // code_word, reconstructed, max_abs_residual
	output logic [1:0]                 m_axis_tuser   // predictor_type
);

	cmd_t    cmd;
	status_t status;

	logic [CODE_W-1:0]          code;
	logic signed [SAMPLE_W-1:0] recon;
	logic [MAG_W-1:0]           maxr;

	pmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	pmq_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.cmd              (cmd),
		.status           (status),
		.in_sample        ($signed(s_axis_tdata)),
		.in_first_channel (s_axis_tuser[0]),
		.in_first_trace   (s_axis_tuser[1]),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_code         (code),
		.out_type         (m_axis_tuser),
		.out_recon        (recon),
		.out_max          (maxr)
	);

	// pack result fields
	assign m_axis_tdata = {maxr, recon, code};

endmodule : predictive_minifloat_quantizer_top
`default_nettype wire
